// ----- sv/kce_pkg.sv -----
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types and constants of the keyframe curve evaluator.
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int TW     = 32;  // time and value width
  localparam int CFG_IW = 8;   // register index width
  localparam int CFG_DW = 32;  // register data width

  localparam logic [CFG_IW-1:0] CFG_INTERP = 8'd0;
  localparam logic [CFG_IW-1:0] CFG_EXTRAP = 8'd1;

  localparam logic [1:0] EXTRAP_LOOP = 2'd1;
  localparam logic [1:0] EXTRAP_PING = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic FUNC_EVAL = 1'b1;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD_FIRST,
    OP_RD_LAST,
    OP_CAP_LAST,
    OP_DIV_WRAP,
    OP_TE_WRAP,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_DIV_MIX,
    OP_MUL,
    OP_RES_MIX,
    OP_RES_KEY,
    OP_RES_LEFT,
    OP_RES_FIRST,
    OP_RES_LAST,
    OP_ST_EMPTY,
    OP_ST_FULL,
    OP_WR_VAL,
    OP_SH_INIT,
    OP_SH_RD,
    OP_SH_WR,
    OP_WR_NEW,
    OP_PUBLISH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_FIRST,
    S_LAST,
    S_DECIDE,
    S_DIVW,
    S_WRAP,
    S_SRD,
    S_SCMP,
    S_DIVM,
    S_MUL,
    S_MIX,
    S_SH_CHK,
    S_SH_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic in_range;
    logic t_lt_first;
    logic wrap_en;
    logic interp_lin;
    logic scan_end;
    logic ge;
    logic eq;
    logic idx_zero;
    logic j_gt_pos;
    logic div_busy;
  } stat_t;

endpackage

// ----- sv/kce_div.sv -----
// ----------------------------------------------------------------------------
// kce_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kce_div #(
  parameter int NW = 49
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NW-1:0]         dividend,
  input  logic [kce_pkg::TW-1:0] divisor,
  output logic                  busy,
  output logic [NW-1:0]         quo,
  output logic [kce_pkg::TW-1:0] rem
);

  localparam int KW = $clog2(NW + 1);

  logic [KW-1:0]          cnt_r;
  logic [NW-1:0]          dvd_r;
  logic [kce_pkg::TW-1:0] div_r;
  logic [kce_pkg::TW-1:0] rem_r;
  logic [kce_pkg::TW:0]   trial;
  logic [kce_pkg::TW:0]   diff;
  logic                   take;

  assign trial = {rem_r, dvd_r[NW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign take  = !diff[kce_pkg::TW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= KW'(NW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      // shift in the next dividend bit, keep the quotient bit in its place
      dvd_r <= {dvd_r[NW-2:0], take};
      rem_r <= take ? diff[kce_pkg::TW-1:0] : trial[kce_pkg::TW-1:0];
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = dvd_r;
  assign rem  = rem_r;

endmodule

// ----- sv/kce_dp.sv -----
// ----------------------------------------------------------------------------
// kce_dp
// Datapath: key table memories, registers, divider, blend multiplier.
// ----------------------------------------------------------------------------
module kce_dp #(
  parameter int MAX_KEYS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kce_pkg::cmd_t              cmd,
  output kce_pkg::stat_t             stat,
  input  logic                       in_func,
  input  logic [kce_pkg::TW-1:0]     in_time_req,
  input  logic [kce_pkg::TW-1:0]     in_key_value,
  input  logic                       cfg_we,
  input  logic [kce_pkg::CFG_IW-1:0] cfg_index,
  input  logic [kce_pkg::CFG_DW-1:0] cfg_data,
  output logic [kce_pkg::TW-1:0]     out_value,
  output logic [1:0]                 out_status
);

  localparam int TW = kce_pkg::TW;
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int NW = TW + 1 + FRAC_BITS;
  localparam int PW = TW + 2 + FRAC_BITS;

  logic [TW-1:0] time_mem [MAX_KEYS];
  logic [TW-1:0] val_mem  [MAX_KEYS];

  logic [CW-1:0] cnt_r, idx_r, pos_r, j_r;
  logic          interp_r;
  logic [1:0]    extrap_r;
  logic          func_r;
  logic [TW-1:0] t_r, v_r, te_r, first_r, fval_r, last_r, lval_r;
  logic [TW-1:0] lt_r, lv_r, rv_r, rd_time_r, rd_val_r;
  logic [TW-1:0] res_value_r, out_value_r;
  logic [1:0]    res_status_r, out_status_r;
  logic signed [PW-1:0] prod_r;

  logic [AW-1:0] raddr, waddr;
  logic          we_t, we_v;
  logic [TW-1:0] wtime, wval;
  logic [CW-1:0] cnt_m1, j_m1;

  logic          div_start, div_busy;
  logic [NW-1:0] div_dvd, div_quo;
  logic [TW-1:0] div_dsr, div_rem;

  logic [TW:0]   since, since_mag, vdiff;
  logic [TW-1:0] dur, r_floor, r_eff, mix_span;
  logic          odd;
  logic [PW-1:0] prod_sh;

  assign cnt_m1 = cnt_r - CW'(1);
  assign j_m1   = j_r - CW'(1);

  // wrap arithmetic
  assign since     = {t_r[TW-1], t_r} - {first_r[TW-1], first_r};
  assign since_mag = since[TW] ? (~since + (TW+1)'(1)) : since;
  assign dur       = last_r - first_r;
  assign mix_span  = te_r - lt_r;
  assign vdiff     = {rv_r[TW-1], rv_r} - {lv_r[TW-1], lv_r};
  assign prod_sh   = prod_r >>> FRAC_BITS;

  always_comb begin
    if (since[TW] && div_rem != '0) begin
      r_floor = dur - div_rem;
      odd     = !div_quo[0];
    end else begin
      r_floor = div_rem;
      odd     = div_quo[0];
    end
    r_eff = (extrap_r == kce_pkg::EXTRAP_PING && odd) ? (dur - r_floor) : r_floor;
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    case (cmd.op)
      kce_pkg::OP_DIV_WRAP: begin
        div_start = 1'b1;
        div_dvd   = NW'(since_mag);
        div_dsr   = dur;
      end
      kce_pkg::OP_DIV_MIX: begin
        div_start = 1'b1;
        div_dvd   = {1'b0, mix_span, {FRAC_BITS{1'b0}}};
        div_dsr   = rd_time_r - lt_r;
      end
      default: ;
    endcase
  end

  kce_div #(.NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // memory port selection
  always_comb begin
    raddr = '0;
    waddr = '0;
    we_t  = 1'b0;
    we_v  = 1'b0;
    wtime = t_r;
    wval  = v_r;
    case (cmd.op)
      kce_pkg::OP_RD_LAST: raddr = cnt_m1[AW-1:0];
      kce_pkg::OP_SCAN_RD: raddr = idx_r[AW-1:0];
      kce_pkg::OP_SH_RD:   raddr = j_m1[AW-1:0];
      kce_pkg::OP_WR_VAL: begin
        waddr = idx_r[AW-1:0];
        we_v  = 1'b1;
      end
      kce_pkg::OP_SH_WR: begin
        waddr = j_r[AW-1:0];
        we_t  = 1'b1;
        we_v  = 1'b1;
        wtime = rd_time_r;
        wval  = rd_val_r;
      end
      kce_pkg::OP_WR_NEW: begin
        waddr = pos_r[AW-1:0];
        we_t  = 1'b1;
        we_v  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_t) time_mem[waddr] <= wtime;
    if (we_v) val_mem[waddr] <= wval;
    rd_time_r <= time_mem[raddr];
    rd_val_r  <= val_mem[raddr];
  end

  // control state: key count and mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      interp_r <= 1'b1;
      extrap_r <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kce_pkg::CFG_INTERP: interp_r <= cfg_data[0];
          kce_pkg::CFG_EXTRAP: extrap_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (cmd.op == kce_pkg::OP_WR_NEW) cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      kce_pkg::OP_LOAD: begin
        func_r       <= in_func;
        t_r          <= in_time_req;
        te_r         <= in_time_req;
        v_r          <= in_key_value;
        idx_r        <= '0;
        res_value_r  <= '0;
        res_status_r <= kce_pkg::ST_OK;
      end
      kce_pkg::OP_RD_LAST: begin
        first_r <= rd_time_r;
        fval_r  <= rd_val_r;
      end
      kce_pkg::OP_CAP_LAST: begin
        last_r <= rd_time_r;
        lval_r <= rd_val_r;
      end
      kce_pkg::OP_TE_WRAP:   te_r <= first_r + r_eff;
      kce_pkg::OP_SCAN_NEXT: begin
        lt_r  <= rd_time_r;
        lv_r  <= rd_val_r;
        idx_r <= idx_r + CW'(1);
      end
      kce_pkg::OP_DIV_MIX:   rv_r <= rd_val_r;
      kce_pkg::OP_MUL:
        prod_r <= $signed({1'b0, div_quo[FRAC_BITS-1:0]}) * $signed(vdiff);
      kce_pkg::OP_RES_MIX:   res_value_r  <= lv_r + prod_sh[TW-1:0];
      kce_pkg::OP_RES_KEY:   res_value_r  <= rd_val_r;
      kce_pkg::OP_RES_LEFT:  res_value_r  <= lv_r;
      kce_pkg::OP_RES_FIRST: res_value_r  <= fval_r;
      kce_pkg::OP_RES_LAST:  res_value_r  <= lval_r;
      kce_pkg::OP_ST_EMPTY:  res_status_r <= kce_pkg::ST_EMPTY;
      kce_pkg::OP_ST_FULL:   res_status_r <= kce_pkg::ST_FULL;
      kce_pkg::OP_SH_INIT: begin
        pos_r <= idx_r;
        j_r   <= cnt_r;
      end
      kce_pkg::OP_SH_WR:     j_r <= j_m1;
      kce_pkg::OP_PUBLISH: begin
        out_value_r  <= res_value_r;
        out_status_r <= res_status_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.func       = (func_r == kce_pkg::FUNC_EVAL);
    stat.cnt_zero   = (cnt_r == '0);
    stat.cnt_one    = (cnt_r == CW'(1));
    stat.full       = (cnt_r == CW'(MAX_KEYS));
    stat.in_range   = ($signed(t_r) >= $signed(first_r)) && ($signed(t_r) <= $signed(last_r));
    stat.t_lt_first = ($signed(t_r) < $signed(first_r));
    stat.wrap_en    = (extrap_r == kce_pkg::EXTRAP_LOOP) || (extrap_r == kce_pkg::EXTRAP_PING);
    stat.interp_lin = interp_r;
    stat.scan_end   = (idx_r == cnt_r);
    stat.ge         = ($signed(rd_time_r) >= $signed(te_r));
    stat.eq         = (rd_time_r == te_r);
    stat.idx_zero   = (idx_r == '0);
    stat.j_gt_pos   = (j_r > pos_r);
    stat.div_busy   = div_busy;
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ----- sv/kce_ctrl.sv -----
// ----------------------------------------------------------------------------
// kce_ctrl
// Controller: sequences search, insertion shift, wrap and blend steps.
// ----------------------------------------------------------------------------
module kce_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  kce_pkg::stat_t stat,
  output kce_pkg::cmd_t  cmd
);

  kce_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kce_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = kce_pkg::OP_NOP;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      kce_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = kce_pkg::OP_LOAD;
          state_nxt = kce_pkg::S_START;
        end
      end
      kce_pkg::S_START: begin
        if (!stat.func) begin
          state_nxt = kce_pkg::S_SRD;
        end else if (stat.cnt_zero) begin
          cmd.op    = kce_pkg::OP_ST_EMPTY;
          state_nxt = kce_pkg::S_DONE;
        end else begin
          cmd.op    = kce_pkg::OP_RD_FIRST;
          state_nxt = kce_pkg::S_FIRST;
        end
      end
      kce_pkg::S_FIRST: begin
        cmd.op    = kce_pkg::OP_RD_LAST;
        state_nxt = kce_pkg::S_LAST;
      end
      kce_pkg::S_LAST: begin
        cmd.op    = kce_pkg::OP_CAP_LAST;
        state_nxt = kce_pkg::S_DECIDE;
      end
      kce_pkg::S_DECIDE: begin
        if (stat.cnt_one) begin
          cmd.op    = kce_pkg::OP_RES_FIRST;
          state_nxt = kce_pkg::S_DONE;
        end else if (stat.in_range) begin
          state_nxt = kce_pkg::S_SRD;
        end else if (!stat.wrap_en) begin
          cmd.op    = stat.t_lt_first ? kce_pkg::OP_RES_FIRST : kce_pkg::OP_RES_LAST;
          state_nxt = kce_pkg::S_DONE;
        end else begin
          cmd.op    = kce_pkg::OP_DIV_WRAP;
          state_nxt = kce_pkg::S_DIVW;
        end
      end
      kce_pkg::S_DIVW: begin
        if (!stat.div_busy) state_nxt = kce_pkg::S_WRAP;
      end
      kce_pkg::S_WRAP: begin
        cmd.op    = kce_pkg::OP_TE_WRAP;
        state_nxt = kce_pkg::S_SRD;
      end
      kce_pkg::S_SRD: begin
        // insert past the last key: no match, append unless the table is full
        if (stat.scan_end) begin
          cmd.op    = stat.full ? kce_pkg::OP_ST_FULL : kce_pkg::OP_SH_INIT;
          state_nxt = stat.full ? kce_pkg::S_DONE : kce_pkg::S_SH_CHK;
        end else begin
          cmd.op    = kce_pkg::OP_SCAN_RD;
          state_nxt = kce_pkg::S_SCMP;
        end
      end
      kce_pkg::S_SCMP: begin
        if (!stat.ge) begin
          cmd.op    = kce_pkg::OP_SCAN_NEXT;
          state_nxt = kce_pkg::S_SRD;
        end else if (!stat.func) begin
          if (stat.eq) begin
            cmd.op    = kce_pkg::OP_WR_VAL;
            state_nxt = kce_pkg::S_DONE;
          end else if (stat.full) begin
            cmd.op    = kce_pkg::OP_ST_FULL;
            state_nxt = kce_pkg::S_DONE;
          end else begin
            cmd.op    = kce_pkg::OP_SH_INIT;
            state_nxt = kce_pkg::S_SH_CHK;
          end
        end else if (stat.eq || stat.idx_zero) begin
          cmd.op    = kce_pkg::OP_RES_KEY;
          state_nxt = kce_pkg::S_DONE;
        end else if (!stat.interp_lin) begin
          cmd.op    = kce_pkg::OP_RES_LEFT;
          state_nxt = kce_pkg::S_DONE;
        end else begin
          cmd.op    = kce_pkg::OP_DIV_MIX;
          state_nxt = kce_pkg::S_DIVM;
        end
      end
      kce_pkg::S_DIVM: begin
        if (!stat.div_busy) state_nxt = kce_pkg::S_MUL;
      end
      kce_pkg::S_MUL: begin
        cmd.op    = kce_pkg::OP_MUL;
        state_nxt = kce_pkg::S_MIX;
      end
      kce_pkg::S_MIX: begin
        cmd.op    = kce_pkg::OP_RES_MIX;
        state_nxt = kce_pkg::S_DONE;
      end
      kce_pkg::S_SH_CHK: begin
        if (stat.j_gt_pos) begin
          cmd.op    = kce_pkg::OP_SH_RD;
          state_nxt = kce_pkg::S_SH_WR;
        end else begin
          cmd.op    = kce_pkg::OP_WR_NEW;
          state_nxt = kce_pkg::S_DONE;
        end
      end
      kce_pkg::S_SH_WR: begin
        cmd.op    = kce_pkg::OP_SH_WR;
        state_nxt = kce_pkg::S_SH_CHK;
      end
      kce_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = kce_pkg::OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = kce_pkg::S_IDLE;
        end
      end
      default: state_nxt = kce_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/keyframe_curve_evaluator.sv -----
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator
// Sorted keyframe table with step/linear interpolation and clamp, loop or
// ping-pong extrapolation, Q16.16 times and values.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_func, in_time_req, in_key_value
//   out     | output    | out_valid / out_ready| out_value, out_status
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. The table scan reads and compares each key visited;
// an insert then shifts each later key with a read and a write. Wrapped
// queries add one pass of the bit-serial divider, linear blends another
// pass plus the multiply step.
// Reset (rst_n low, synchronous) empties the table, sets linear blend, clamp.
// A waiting result does not block the next beat; only publishing waits.
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator #(
  parameter int MAX_KEYS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [31:0]                in_time_req,
  input  logic [31:0]                in_key_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_value,
  output logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kce_pkg::CFG_IW-1:0] cfg_index,
  input  logic [kce_pkg::CFG_DW-1:0] cfg_data
);

  kce_pkg::cmd_t  cmd;
  kce_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  kce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kce_dp #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (in_func),
    .in_time_req  (in_time_req),
    .in_key_value (in_key_value),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_value    (out_value),
    .out_status   (out_status)
  );

endmodule

// ----- sv/kce_chk.sv -----
// ----------------------------------------------------------------------------
// kce_chk
// Port-level checks of the keyframe curve evaluator.
// ----------------------------------------------------------------------------
module kce_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == kce_pkg::ST_OK || out_status == kce_pkg::ST_EMPTY ||
                   out_status == kce_pkg::ST_FULL))
    else $error("unknown status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != kce_pkg::ST_OK |-> out_value == '0)
    else $error("error beat carries a value");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyframe_curve_evaluator kce_chk u_kce_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_value  (out_value),
  .out_status (out_status)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Keyframe curve evaluator testbench
// Builds keyframe tables through insert beats, evaluates them under every
// interpolation and extrapolation setting, and checks each result against a
// predictor of the sorted table. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKEYS = 16;
  localparam int FB    = 16;
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic [1:0] EXTRAP_CLAMP = 2'd0;
  localparam logic [1:0] EXTRAP_SPARE = 2'd3;
  localparam logic [kce_pkg::CFG_IW-1:0] CFG_BOGUS = 8'd2;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } curve_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [31:0] in_time_req = '0;
  logic [31:0] in_key_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_value;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [kce_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [kce_pkg::CFG_DW-1:0] cfg_data = '0;

  keyframe_curve_evaluator uut (.*);

  // predictor state
  longint     tbl_t[NKEYS];
  longint     tbl_v[NKEYS];
  int         tbl_n;
  logic       lin_mode;
  logic [1:0] wrap_mode;
  curve_res_t expected_q[$];
  int         err_count;
  longint     cycles;
  int         stall_pct;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    err_count++;
  endtask

  // receiver: stall pattern with a changing density
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    curve_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat value %h status %0d", out_value, out_status));
      end else begin
        exp_r = expected_q.pop_front();
        if (out_value !== exp_r.value)
          report($sformatf("value %h, want %h", out_value, exp_r.value));
        if (out_status !== exp_r.status)
          report($sformatf("status %0d, want %0d", out_status, exp_r.status));
      end
    end
  end

  function automatic int first_at_or_after(longint t);
    int i;
    for (i = 0; i < tbl_n; i++) if (tbl_t[i] >= t) break;
    return i;
  endfunction

  function automatic longint floor_q16(longint p);
    if (p >= 0) return p >>> FB;
    return -((-p + (64'sd1 <<< FB) - 1) >>> FB);
  endfunction

  function automatic longint blend_inside(longint t);
    int     i;
    longint lt, rt, lv, rv, mix;
    i = first_at_or_after(t);
    if (i >= tbl_n) return tbl_v[tbl_n-1];
    if (tbl_t[i] == t || i == 0) return tbl_v[i];
    lt = tbl_t[i-1]; rt = tbl_t[i]; lv = tbl_v[i-1]; rv = tbl_v[i];
    if (!lin_mode) return lv;
    mix = ((t - lt) <<< FB) / (rt - lt);
    return lv + floor_q16(mix * (rv - lv));
  endfunction

  function automatic longint curve_at(longint t);
    int     i;
    longint first, last, dur, since, q, r;
    i = first_at_or_after(t);
    if (i < tbl_n && tbl_t[i] == t) return tbl_v[i];
    if (tbl_n == 1) return tbl_v[0];
    first = tbl_t[0];
    last  = tbl_t[tbl_n-1];
    if (t >= first && t <= last) return blend_inside(t);
    if (wrap_mode != kce_pkg::EXTRAP_LOOP && wrap_mode != kce_pkg::EXTRAP_PING)
      return (t < first) ? tbl_v[0] : tbl_v[tbl_n-1];
    dur = last - first;
    since = t - first;
    q = since / dur;
    r = since % dur;
    if (r < 0) begin
      r += dur;
      q -= 1;
    end
    if (wrap_mode == kce_pkg::EXTRAP_PING && q[0]) r = dur - r;
    return blend_inside(first + r);
  endfunction

  function automatic curve_res_t predict_curve(logic f, logic [31:0] tr, logic [31:0] kv);
    curve_res_t r;
    longint t, v;
    int pos;
    t = longint'($signed(tr));
    v = longint'($signed(kv));
    r.value = '0;
    r.status = kce_pkg::ST_OK;
    if (f == FUNC_INSERT) begin
      pos = first_at_or_after(t);
      if (pos < tbl_n && tbl_t[pos] == t) tbl_v[pos] = v;
      else if (tbl_n >= NKEYS) r.status = kce_pkg::ST_FULL;
      else begin
        for (int j = tbl_n; j > pos; j--) begin
          tbl_t[j] = tbl_t[j-1];
          tbl_v[j] = tbl_v[j-1];
        end
        tbl_t[pos] = t;
        tbl_v[pos] = v;
        tbl_n++;
      end
    end else if (tbl_n == 0) begin
      r.status = kce_pkg::ST_EMPTY;
    end else begin
      r.value = 32'(curve_at(t));
    end
    return r;
  endfunction

  // send one beat; gaps come in random bursts, valid drops only in a gap
  int burst_left;
  task automatic send_item(input logic f, input logic [31:0] tr, input logic [31:0] kv);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= f;
    in_time_req <= tr;
    in_key_value <= kv;
    expected_q.push_back(predict_curve(f, tr, kv));
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [kce_pkg::CFG_IW-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == kce_pkg::CFG_INTERP) lin_mode = d[0];
    else if (idx == kce_pkg::CFG_EXTRAP) wrap_mode = d[1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_modes(input logic lin, input logic [1:0] ex);
    drain();
    write_reg(kce_pkg::CFG_INTERP, {$urandom() & 32'hFFFF_FFFE} | lin);
    write_reg(kce_pkg::CFG_EXTRAP, {$urandom() & 32'hFFFF_FFFC} | ex);
  endtask

  task automatic test_directed();
    send_item(kce_pkg::FUNC_EVAL, 32'h0, 32'hFFFF_FFFF);  // empty table
    send_item(FUNC_INSERT, 32'h0001_0000, 32'h8000_0000);
    send_item(kce_pkg::FUNC_EVAL, 32'h7FFF_FFFF, 32'h0);   // single key
    send_item(kce_pkg::FUNC_EVAL, 32'h8000_0000, 32'h0);
    send_item(FUNC_INSERT, 32'h0005_0000, 32'h7FFF_FFFF);
    send_item(FUNC_INSERT, 32'h0001_0000, 32'h8000_0000); // overwrite
    send_item(kce_pkg::FUNC_EVAL, 32'h0003_8000, 32'h0);
    send_item(kce_pkg::FUNC_EVAL, 32'h0005_0000, 32'h0);
    send_item(kce_pkg::FUNC_EVAL, 32'h8000_0000, 32'h0);
    send_item(kce_pkg::FUNC_EVAL, 32'h7FFF_FFFF, 32'h0);
    set_modes(1'b1, kce_pkg::EXTRAP_LOOP);
    send_item(kce_pkg::FUNC_EVAL, 32'h0009_0000, 32'h0);   // wraps onto first key
    send_item(kce_pkg::FUNC_EVAL, 32'h8000_0000, 32'h0);
    send_item(kce_pkg::FUNC_EVAL, 32'h7FFF_FFFF, 32'h0);
    set_modes(1'b0, kce_pkg::EXTRAP_PING);
    send_item(kce_pkg::FUNC_EVAL, 32'h0007_0000, 32'h0);
    send_item(kce_pkg::FUNC_EVAL, 32'hFFFE_0000, 32'h0);
    send_item(kce_pkg::FUNC_EVAL, 32'h8000_0000, 32'h0);
    set_modes(1'b1, EXTRAP_SPARE);
    send_item(kce_pkg::FUNC_EVAL, 32'h7FFF_FFFF, 32'h0);
    drain();
    write_reg(CFG_BOGUS, 32'hFFFF_FFFF);
    send_item(kce_pkg::FUNC_EVAL, 32'h8000_0000, 32'h0);
  endtask

  // fill to the limit, then probe full-table behavior
  task automatic test_full_table();
    for (int k = 0; k < NKEYS + 3; k++)
      send_item(FUNC_INSERT, $urandom(), $urandom());
    send_item(FUNC_INSERT, 32'h0005_0000, $urandom());    // overwrite when full
    send_item(kce_pkg::FUNC_EVAL, 32'h7FFF_FFFF, 32'h0);
  endtask

  function automatic logic [31:0] pick_time();
    int k;
    case ($urandom_range(5))
      0: return $urandom();
      1: return tbl_n ? 32'(tbl_t[$urandom_range(tbl_n-1)]) : $urandom();
      2: begin
        k = (tbl_n > 1) ? $urandom_range(tbl_n-2) : 0;
        return tbl_n ? 32'(tbl_t[k] + $urandom_range(0, 32'h3_0000)) : $urandom();
      end
      3: return $urandom_range(0, 32'h40_0000) - 32'h20_0000;
      4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom()) >>> $urandom_range(31));
    endcase
  endfunction

  // rounds of inserts and queries on the one table, each under random modes
  task automatic test_random();
    int items;
    items = 0;
    while (items < 1200) begin
      stall_pct = $urandom_range(2) * 35;
      set_modes(1'($urandom_range(1)), 2'($urandom_range(3)));
      repeat ($urandom_range(2, 8)) begin
        send_item(FUNC_INSERT, pick_time(), $urandom());
        items++;
      end
      repeat ($urandom_range(20, 60)) begin
        send_item($urandom_range(7) != 0, pick_time(), $urandom());
        items++;
      end
    end
  endtask

  initial begin
    tbl_n = 0;
    lin_mode = 1'b1;
    wrap_mode = EXTRAP_CLAMP;
    err_count = 0;
    cycles = 0;
    stall_pct = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_random();
    drain();
    if (err_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
